FILE: rtl/lkc_pkg.sv
package lkc_pkg;

    localparam int unsigned StateWidth = 31;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ShiftWidth = 5;
    localparam int unsigned MultWidth  = 15;
    localparam int unsigned ShiftPos   = 27;

    typedef logic [StateWidth-1:0] lkc_state_t;
    typedef logic [CharWidth-1:0]  lkc_char_t;
    typedef logic [ShiftWidth-1:0] lkc_shift_t;

    localparam lkc_state_t           LcgMod    = 31'h7FFF_FFFF;
    localparam logic [MultWidth-1:0] LcgMult   = 15'd16807;
    localparam lkc_state_t           SeedReset = 31'd1;

    localparam lkc_char_t LetterFirst = 8'd65;
    localparam lkc_char_t LetterLast  = 8'd90;
    localparam lkc_char_t Alphabet    = 8'd26;

    localparam logic ModeEncrypt = 1'b0;
    localparam logic ModeDecrypt = 1'b1;

    function automatic logic is_letter(lkc_char_t c);
        return (c >= LetterFirst) && (c <= LetterLast);
    endfunction

endpackage

FILE: rtl/lehmer_keystream_letter_cipher.sv
// A character accepted into the input register moves on to the result register when that
// register is free, and its result is then offered on char_out and shift_used.
// Throughput: one character per clock cycle, sustained with out_ready held high.
// The generator state advances in the same cycle the input register moves to the
// output register, so the single 31x15 multiply and fold set the clock period.
// Reset empties both registers and sets the seed and generator state to one.
module lehmer_keystream_letter_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lkc_pkg::lkc_char_t  char_in,
    input  logic                mode,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output lkc_pkg::lkc_char_t  char_out,
    output lkc_pkg::lkc_shift_t shift_used,
    input  logic                cfg_write_en,
    input  lkc_pkg::lkc_state_t cfg_write_data
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    lkc_pkg::lkc_char_t  s1_char_reg;
    logic                s1_mode_reg;
    logic                s1_restart_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    lkc_pkg::lkc_char_t  out_char_reg;
    lkc_pkg::lkc_shift_t out_shift_reg;
    lkc_pkg::lkc_state_t gen_state_reg;
    lkc_pkg::lkc_state_t seed_reg;

    lkc_pkg::lkc_state_t step_state;
    lkc_pkg::lkc_shift_t step_shift;
    lkc_pkg::lkc_char_t  step_char;

    logic in_fire;
    logic out_free;
    logic s1_fire;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign in_fire  = in_valid && in_ready;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && !out_ready);

    lkc_step u_step (
        .state_cur (gen_state_reg),
        .seed      (seed_reg),
        .restart   (s1_restart_reg),
        .mode      (s1_mode_reg),
        .char_in   (s1_char_reg),
        .state_new (step_state),
        .shift     (step_shift),
        .char_out  (step_char)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gen_state_reg <= lkc_pkg::SeedReset;
            seed_reg      <= lkc_pkg::SeedReset;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
                gen_state_reg <= step_state;
            if (cfg_write_en)
                seed_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_char_reg    <= char_in;
            s1_mode_reg    <= mode;
            s1_restart_reg <= restart;
        end
        if (s1_fire)
        begin
            out_char_reg  <= step_char;
            out_shift_reg <= step_shift;
        end
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = out_char_reg;
    assign shift_used = out_shift_reg;

    a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_state_reg != '0)
        else $error("Generator state reached zero.");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_shift_reg >= 5'd1 && out_shift_reg <= 5'd16))
        else $error("Shift outside one to sixteen.");

    a_nonletter_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !lkc_pkg::is_letter(s1_char_reg))
        |=> (out_char_reg == $past(s1_char_reg)))
        else $error("Non-letter byte was altered.");

    a_letter_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && lkc_pkg::is_letter(s1_char_reg))
        |=> lkc_pkg::is_letter(out_char_reg))
        else $error("Letter mapped outside the alphabet.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("Input stalled with room in the pipeline.");

endmodule

FILE: rtl/lkc_step.sv
module lkc_step (
    input  lkc_pkg::lkc_state_t state_cur,
    input  lkc_pkg::lkc_state_t seed,
    input  logic                restart,
    input  logic                mode,
    input  lkc_pkg::lkc_char_t  char_in,
    output lkc_pkg::lkc_state_t state_new,
    output lkc_pkg::lkc_shift_t shift,
    output lkc_pkg::lkc_char_t  char_out
);

    localparam int unsigned ProdWidth = lkc_pkg::StateWidth + lkc_pkg::MultWidth;

    lkc_pkg::lkc_state_t         seed_load;
    lkc_pkg::lkc_state_t         state_base;
    logic [ProdWidth-1:0]        product;
    logic [lkc_pkg::StateWidth:0] folded;
    logic [lkc_pkg::StateWidth:0] reduced;
    logic [lkc_pkg::CharWidth:0]  enc_sum;
    logic [lkc_pkg::CharWidth:0]  enc_wrap;
    logic [lkc_pkg::CharWidth:0]  dec_diff;
    logic [lkc_pkg::CharWidth:0]  dec_wrap;

    // A zero seed is loaded as one so the generator never sticks at zero.
    assign seed_load  = (seed == '0) ? lkc_pkg::SeedReset : seed;
    assign state_base = restart ? seed_load : state_cur;

    // The product is folded at bit 31, since 2^31 is one modulo 2^31-1.
    assign product = {{lkc_pkg::MultWidth{1'b0}}, state_base}
                   * {{lkc_pkg::StateWidth{1'b0}}, lkc_pkg::LcgMult};
    assign folded  = {1'b0, product[lkc_pkg::StateWidth-1:0]}
                   + {{(2*lkc_pkg::StateWidth+1-ProdWidth){1'b0}},
                      product[ProdWidth-1:lkc_pkg::StateWidth]};
    assign reduced = (folded >= {1'b0, lkc_pkg::LcgMod})
                   ? folded - {1'b0, lkc_pkg::LcgMod} : folded;

    assign state_new = (reduced == '0) ? lkc_pkg::LcgMod
                                       : reduced[lkc_pkg::StateWidth-1:0];
    assign shift = {1'b0, state_new[lkc_pkg::StateWidth-1:lkc_pkg::ShiftPos]}
                 + lkc_pkg::lkc_shift_t'(1);

    assign enc_sum  = {1'b0, char_in} + {4'b0, shift};
    assign enc_wrap = (enc_sum > {1'b0, lkc_pkg::LetterLast})
                    ? enc_sum - {1'b0, lkc_pkg::Alphabet} : enc_sum;
    assign dec_diff = {1'b0, char_in} - {4'b0, shift};
    assign dec_wrap = (dec_diff < {1'b0, lkc_pkg::LetterFirst})
                    ? dec_diff + {1'b0, lkc_pkg::Alphabet} : dec_diff;

    always_comb
    begin
        char_out = char_in;
        if (lkc_pkg::is_letter(char_in))
        begin
            if (mode == lkc_pkg::ModeDecrypt)
                char_out = dec_wrap[lkc_pkg::CharWidth-1:0];
            else
                char_out = enc_wrap[lkc_pkg::CharWidth-1:0];
        end
    end

endmodule

FILE: verif/testbench.sv
module testbench;

    localparam int unsigned StallLimit    = 4000;
    localparam int unsigned LongHoldOff   = 64;
    localparam int unsigned PhaseItems    = 105;
    localparam int unsigned PhaseCount    = 8;

    typedef struct packed {
        lkc_pkg::lkc_char_t ch;
        logic               decrypt;
        logic               reload;
    } char_item_t;

    typedef struct packed {
        lkc_pkg::lkc_char_t  ch;
        lkc_pkg::lkc_shift_t shift;
    } cipher_out_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    lkc_pkg::lkc_char_t  char_in = '0;
    logic                mode = lkc_pkg::ModeEncrypt;
    logic                restart = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lkc_pkg::lkc_char_t  char_out;
    lkc_pkg::lkc_shift_t shift_used;
    logic                cfg_write_en = 1'b0;
    lkc_pkg::lkc_state_t cfg_write_data = '0;

    char_item_t  char_stream_q[$];
    cipher_out_t predicted_ciphers[$];
    char_item_t  next_item;
    cipher_out_t seen_cipher;

    lkc_pkg::lkc_state_t keystream_state = lkc_pkg::SeedReset;
    lkc_pkg::lkc_state_t seed_shadow = lkc_pkg::SeedReset;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        stall_trigger = 1'b0;
    logic        stall_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;

    lehmer_keystream_letter_cipher dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_in        (char_in),
        .mode           (mode),
        .restart        (restart),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .char_out       (char_out),
        .shift_used     (shift_used),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lkc_pkg::lkc_state_t lehmer_next(input lkc_pkg::lkc_state_t s);
        logic [45:0] prod;
        logic [31:0] fold;
        prod = {15'b0, s} * {31'b0, lkc_pkg::LcgMult};
        fold = {1'b0, prod[30:0]} + {17'b0, prod[45:31]};
        if (fold >= {1'b0, lkc_pkg::LcgMod})
        begin
            fold = fold - {1'b0, lkc_pkg::LcgMod};
        end
        if (fold == '0)
        begin
            fold = {1'b0, lkc_pkg::LcgMod};
        end
        return fold[30:0];
    endfunction

    task automatic encipher_step(input char_item_t item);
        cipher_out_t         res;
        logic [8:0]          v;
        lkc_pkg::lkc_shift_t k;
        if (item.reload)
        begin
            keystream_state = (seed_shadow == '0) ? lkc_pkg::SeedReset : seed_shadow;
        end
        keystream_state = lehmer_next(keystream_state);
        k = {1'b0, keystream_state[lkc_pkg::ShiftPos +: 4]} + 5'd1;
        v = {1'b0, item.ch};
        if (item.ch >= lkc_pkg::LetterFirst && item.ch <= lkc_pkg::LetterLast)
        begin
            if (item.decrypt == lkc_pkg::ModeEncrypt)
            begin
                v = {1'b0, item.ch} + {4'b0, k};
                if (v > {1'b0, lkc_pkg::LetterLast})
                begin
                    v = v - {1'b0, lkc_pkg::Alphabet};
                end
            end
            else
            begin
                v = {1'b0, item.ch} - {4'b0, k};
                if (v < {1'b0, lkc_pkg::LetterFirst})
                begin
                    v = v + {1'b0, lkc_pkg::Alphabet};
                end
            end
        end
        res.ch = v[7:0];
        res.shift = k;
        predicted_ciphers.push_back(res);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                encipher_step('{ch: char_in, decrypt: mode, reload: restart});
            end
            if (!in_valid || in_ready)
            begin
                if (char_stream_q.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_item = char_stream_q.pop_front();
                    in_valid <= 1'b1;
                    char_in  <= next_item.ch;
                    mode     <= next_item.decrypt;
                    restart  <= next_item.reload;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (stall_trigger != stall_seen)
        begin
            stall_seen <= stall_trigger;
            hold_left  <= LongHoldOff;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_ciphers.size() == 0)
            begin
                $error("unexpected transaction: char_out %0d, shift_used %0d",
                       char_out, shift_used);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                seen_cipher = predicted_ciphers.pop_front();
                if (char_out !== seen_cipher.ch)
                begin
                    $error("char_out mismatch: expected %0d, actual %0d",
                           seen_cipher.ch, char_out);
                    mismatch_count = mismatch_count + 1;
                end
                if (shift_used !== seen_cipher.shift)
                begin
                    $error("shift_used mismatch: expected %0d, actual %0d",
                           seen_cipher.shift, shift_used);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit)
        begin
            $display("lehmer_keystream_letter_cipher verification failed");
            $finish;
        end
    end

    task automatic push_char(input lkc_pkg::lkc_char_t c, input logic m, input logic r);
        char_stream_q.push_back('{ch: c, decrypt: m, reload: r});
    endtask

    task automatic wait_drained();
        while (char_stream_q.size() != 0 || in_valid || predicted_ciphers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_seed(input lkc_pkg::lkc_state_t v);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        seed_shadow = v;
    endtask

    initial
    begin
        lkc_pkg::lkc_state_t seed;
        lkc_pkg::lkc_char_t  c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        push_char("A", lkc_pkg::ModeEncrypt, 1'b1);
        push_char("Z", lkc_pkg::ModeEncrypt, 1'b0);
        push_char("A", lkc_pkg::ModeDecrypt, 1'b0);
        push_char("Z", lkc_pkg::ModeDecrypt, 1'b0);
        push_char("@", lkc_pkg::ModeEncrypt, 1'b0);
        push_char("[", lkc_pkg::ModeDecrypt, 1'b0);
        push_char(" ", lkc_pkg::ModeEncrypt, 1'b0);
        push_char(8'h00, lkc_pkg::ModeEncrypt, 1'b0);
        push_char(8'hFF, lkc_pkg::ModeDecrypt, 1'b0);
        push_char("a", lkc_pkg::ModeEncrypt, 1'b0);
        push_char("z", lkc_pkg::ModeDecrypt, 1'b0);
        push_char(8'h7F, lkc_pkg::ModeEncrypt, 1'b0);
        push_char(8'h80, lkc_pkg::ModeDecrypt, 1'b0);
        push_char("M", lkc_pkg::ModeEncrypt, 1'b1);
        push_char("M", lkc_pkg::ModeDecrypt, 1'b1);
        wait_drained();

        write_seed('0);
        @(negedge clk);
        push_char("Q", lkc_pkg::ModeEncrypt, 1'b1);
        push_char("Q", lkc_pkg::ModeDecrypt, 1'b0);
        wait_drained();

        write_seed(lkc_pkg::LcgMod);
        @(negedge clk);
        push_char("Z", lkc_pkg::ModeEncrypt, 1'b1);
        push_char("A", lkc_pkg::ModeDecrypt, 1'b0);
        push_char("B", lkc_pkg::ModeEncrypt, 1'b0);
        wait_drained();

        write_seed(lkc_pkg::lkc_state_t'(lkc_pkg::LcgMod - 1));
        @(negedge clk);
        push_char("Y", lkc_pkg::ModeEncrypt, 1'b1);
        push_char("C", lkc_pkg::ModeDecrypt, 1'b0);
        wait_drained();

        for (int p = 0; p < PhaseCount; p++)
        begin
            case (p % 4)
                0: seed = lkc_pkg::lkc_state_t'($urandom);
                1: seed = (p == 5) ? '0 : lkc_pkg::lkc_state_t'($urandom);
                2: seed = lkc_pkg::lkc_state_t'($urandom_range(65535, 1));
                default: seed = (p == 3) ? lkc_pkg::lkc_state_t'(lkc_pkg::LcgMod - 1)
                                         : lkc_pkg::lkc_state_t'($urandom);
            endcase
            write_seed(seed);
            case (p % 4)
                0:
                begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                end
                1:
                begin
                    sender_idle_pct <= 83;
                    recv_stall_pct  <= 0;
                end
                2:
                begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 83;
                end
                default:
                begin
                    sender_idle_pct <= 26;
                    recv_stall_pct  <= 26;
                end
            endcase
            if (p == 0)
            begin
                stall_trigger <= ~stall_trigger;
            end
            @(negedge clk);
            for (int i = 0; i < PhaseItems; i++)
            begin
                if ($urandom_range(9) < 6)
                begin
                    c = lkc_pkg::lkc_char_t'(lkc_pkg::LetterFirst + $urandom_range(25));
                end
                else
                begin
                    c = lkc_pkg::lkc_char_t'($urandom_range(255));
                end
                push_char(c, 1'($urandom_range(1)), (i == 0) || ($urandom_range(19) == 0));
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (predicted_ciphers.size() != 0)
        begin
            $error("%0d expected transactions never arrived", predicted_ciphers.size());
        end
        if (mismatch_count == 0 && predicted_ciphers.size() == 0)
        begin
            $display("lehmer_keystream_letter_cipher verification clean");
        end
        else
        begin
            $display("lehmer_keystream_letter_cipher verification failed");
        end
        $finish;
    end

endmodule
